@@ sv/eia_pkg.sv @@
// Shared constants, request/result types and internal command structs of the ID allocator.
package eia_pkg;

    localparam int NUM_ENTITIES   = 1024;
    localparam int SIGNATURE_BITS = 32;
    localparam int ID_W           = $clog2(NUM_ENTITIES);
    localparam int CNT_W          = $clog2(NUM_ENTITIES + 1);

    // Fixed field widths of the request and result ports
    localparam int ID_IN_W   = 11;
    localparam int ENT_OUT_W = 10;
    localparam int SIG_IO_W  = 32;
    localparam int TOTAL_W   = 11;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_SET     = 2'd2,
        OP_GET     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_NO_FREE    = 2'd1,
        STS_RANGE      = 2'd2,
        STS_NOT_LIVING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [ID_IN_W-1:0]  entity_id;
        logic [SIG_IO_W-1:0] signature_in;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ENT_OUT_W-1:0] entity_out;
        logic [SIG_IO_W-1:0]  signature_out;
        logic [TOTAL_W-1:0]   living_total;
    } t_rsp;

    typedef struct packed {
        logic            pop;
        logic            push;
        logic [ID_W-1:0] push_id;
    } t_ring_cmd;

    typedef struct packed {
        logic                      sig_we;
        logic [ID_W-1:0]           sig_addr;
        logic [SIGNATURE_BITS-1:0] sig_wdata;
        logic                      live_we;
        logic [ID_W-1:0]           live_addr;
        logic                      live_wdata;
    } t_tbl_cmd;

    // Advance a ring pointer, wrapping at the ring depth
    function automatic logic [ID_W-1:0] ptr_next(input logic [ID_W-1:0] p);
        logic [ID_W-1:0] r;
        if (p == ID_W'(NUM_ENTITIES - 1)) begin
            r = '0;
        end else begin
            r = p + ID_W'(1);
        end
        return r;
    endfunction

endpackage

@@ sv/eia_ram.sv @@
// Simple dual-port synchronous RAM with one write port and a registered read port.
module eia_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/eia_ring.sv @@
// Free ID ring: RAM plus head/tail pointers; unwritten slots read as their own index.
module eia_ring
    import eia_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ring_cmd       i_cmd,
    output logic [ID_W-1:0] o_pop_id
);

    logic [ID_W-1:0] r_head;
    logic [ID_W-1:0] r_tail;
    logic            r_wrapped;
    logic [ID_W-1:0] r_rd_addr;
    logic            r_rd_written;
    logic [ID_W-1:0] n_head;
    logic [ID_W-1:0] n_tail;
    logic            n_wrapped;
    logic [ID_W-1:0] ram_q;

    eia_ram #(
        .DEPTH  (NUM_ENTITIES),
        .DATA_W (ID_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.push_id),
        .i_raddr (r_head),
        .o_rdata (ram_q)
    );

    // Advance pointers on pop and push; note once the tail has covered every slot
    always_comb begin
        n_head    = i_cmd.pop ? ptr_next(r_head) : r_head;
        n_tail    = i_cmd.push ? ptr_next(r_tail) : r_tail;
        n_wrapped = r_wrapped
                    || (i_cmd.push && (r_tail == ID_W'(NUM_ENTITIES - 1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_wrapped <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_wrapped <= n_wrapped;
        end
    end

    // Track whether the slot read this cycle has ever been written
    always_ff @(posedge i_clk) begin
        r_rd_addr    <= r_head;
        r_rd_written <= r_wrapped || (r_head < r_tail);
    end

    // Slots never written still hold their reset ID
    assign o_pop_id = r_rd_written ? ram_q : r_rd_addr;

endmodule

@@ sv/eia_table.sv @@
// Entity table: signature RAM and living-mark RAM, cleared by a sweep after reset.
module eia_table
    import eia_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_tbl_cmd                  i_cmd,
    input  logic [ID_W-1:0]           i_raddr,
    output logic [SIGNATURE_BITS-1:0] o_sig,
    output logic                      o_living,
    output logic                      o_clearing
);

    logic            r_clr_active;
    logic [ID_W-1:0] r_clr_addr;

    logic                      sig_we;
    logic [ID_W-1:0]           sig_waddr;
    logic [SIGNATURE_BITS-1:0] sig_wdata;
    logic                      live_we;
    logic [ID_W-1:0]           live_waddr;
    logic                      live_wdata;

    // Sweep every entry to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= ptr_next(r_clr_addr);
            if (r_clr_addr == ID_W'(NUM_ENTITIES - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Select the sweep or the command as the write source
    always_comb begin
        if (r_clr_active) begin
            sig_we     = 1'b1;
            sig_waddr  = r_clr_addr;
            sig_wdata  = '0;
            live_we    = 1'b1;
            live_waddr = r_clr_addr;
            live_wdata = 1'b0;
        end else begin
            sig_we     = i_cmd.sig_we;
            sig_waddr  = i_cmd.sig_addr;
            sig_wdata  = i_cmd.sig_wdata;
            live_we    = i_cmd.live_we;
            live_waddr = i_cmd.live_addr;
            live_wdata = i_cmd.live_wdata;
        end
    end

    eia_ram #(
        .DEPTH  (NUM_ENTITIES),
        .DATA_W (SIGNATURE_BITS)
    ) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (sig_we),
        .i_waddr (sig_waddr),
        .i_wdata (sig_wdata),
        .i_raddr (i_raddr),
        .o_rdata (o_sig)
    );

    eia_ram #(
        .DEPTH  (NUM_ENTITIES),
        .DATA_W (1)
    ) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (live_we),
        .i_waddr (live_waddr),
        .i_wdata (live_wdata),
        .i_raddr (i_raddr),
        .o_rdata (o_living)
    );

    assign o_clearing = r_clr_active;

endmodule

@@ sv/entity_id_allocator_unit.sv @@
// Top level of the entity ID allocator: request sequencer, living count and result register.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-----------------------------------
//  request   | in        | start high, busy low| i_req (op, entity_id, signature_in)
//  result    | out       | o_valid, one cycle  | o_rsp (status, entity_out,
//            |           |                     |        signature_out, living_total)
//
// A request is handled in an execute state: the table and ring RAMs are read at the accept
// edge, and the execute cycle updates them and registers the result, shown the cycle after.
// busy is high in that execute cycle, so no new request is taken while one executes.
// After reset the table is swept to zero with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module entity_id_allocator_unit
    import eia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_state r_state;
    t_state n_state;
    t_req   r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic   r_valid;
    logic   n_valid;
    t_rsp   r_rsp;
    t_rsp   n_rsp;

    t_ring_cmd ring_cmd;
    t_tbl_cmd  tbl_cmd;
    logic [ID_W-1:0]           pop_id;
    logic [SIGNATURE_BITS-1:0] tbl_sig;
    logic                      tbl_living;
    logic                      tbl_clearing;
    logic                      accept;
    logic                      out_of_range;
    logic [ID_W-1:0]           tgt_id;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    eia_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ring_cmd),
        .o_pop_id (pop_id)
    );

    eia_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .i_raddr    (i_req.entity_id[ID_W-1:0]),
        .o_sig      (tbl_sig),
        .o_living   (tbl_living),
        .o_clearing (tbl_clearing)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (!tbl_clearing) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign out_of_range = (r_req.entity_id >= ID_IN_W'(NUM_ENTITIES));
    assign tgt_id       = r_req.entity_id[ID_W-1:0];

    // Update the memories and build the result in the execute cycle
    always_comb begin
        ring_cmd             = '0;
        tbl_cmd              = '0;
        n_count              = r_count;
        n_valid              = 1'b0;
        n_rsp.status         = STS_OK;
        n_rsp.entity_out     = ENT_OUT_W'(r_req.entity_id);
        n_rsp.signature_out  = '0;
        n_rsp.living_total   = TOTAL_W'(r_count);
        tbl_cmd.sig_addr     = tgt_id;
        tbl_cmd.live_addr    = tgt_id;
        ring_cmd.push_id     = tgt_id;
        if (r_state == ST_EXEC) begin
            n_valid = 1'b1;
            priority if (r_req.op == OP_CREATE) begin
                if (r_count >= CNT_W'(NUM_ENTITIES)) begin
                    n_rsp.status     = STS_NO_FREE;
                    n_rsp.entity_out = '0;
                end else begin
                    ring_cmd.pop       = 1'b1;
                    tbl_cmd.live_we    = 1'b1;
                    tbl_cmd.live_addr  = pop_id;
                    tbl_cmd.live_wdata = 1'b1;
                    n_count            = r_count + CNT_W'(1);
                    n_rsp.entity_out   = ENT_OUT_W'(pop_id);
                end
            end else if (out_of_range) begin
                n_rsp.status = STS_RANGE;
            end else if (r_req.op == OP_DESTROY) begin
                if (!tbl_living) begin
                    n_rsp.status = STS_NOT_LIVING;
                end else begin
                    tbl_cmd.sig_we     = 1'b1;
                    tbl_cmd.sig_wdata  = '0;
                    tbl_cmd.live_we    = 1'b1;
                    tbl_cmd.live_wdata = 1'b0;
                    ring_cmd.push      = 1'b1;
                    n_count            = r_count - CNT_W'(1);
                end
            end else if (r_req.op == OP_SET) begin
                tbl_cmd.sig_we    = 1'b1;
                tbl_cmd.sig_wdata = SIGNATURE_BITS'(r_req.signature_in);
            end else begin
                n_rsp.signature_out = SIG_IO_W'(tbl_sig);
            end
            n_rsp.living_total = TOTAL_W'(n_count);
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Capture the request and the result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // The living count never exceeds the number of IDs
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_ENTITIES))
        else $error("living count above number of entities");

    // A result follows every execute cycle
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> o_valid)
        else $error("execute cycle gave no result");

    // Results are never shown in consecutive cycles
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results in consecutive cycles");

    // No request leaves idle while the table sweep runs
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_clearing |-> busy)
        else $error("request possible during table sweep");

endmodule

@@ verif/eia_checker.sv @@
// Checker for the entity ID allocator: request predictor and result scoreboard.
module eia_checker
    import eia_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  t_req                    i_req,
    input  logic                    i_valid,
    input  t_rsp                    i_rsp,
    input  logic                    i_end,
    output int                      o_errors,
    output int                      o_pending,
    output logic [NUM_ENTITIES-1:0] o_live_map
);

    localparam int MAX_PRINTS = 100;

    // Predicted allocator state
    logic [ID_W-1:0]           free_ring [NUM_ENTITIES];
    logic [ID_W-1:0]           ring_rd;
    logic [ID_W-1:0]           ring_wr;
    logic [CNT_W-1:0]          live_cnt;
    logic [SIGNATURE_BITS-1:0] sig_table [NUM_ENTITIES];
    logic [NUM_ENTITIES-1:0]   live_map;

    t_rsp rsp_due [$];
    int   err_cnt = 0;
    bit   end_seen = 1'b0;

    // Print one mismatch line and count it
    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    function automatic logic [ID_W-1:0] ring_adv(input logic [ID_W-1:0] p);
        return (p == ID_W'(NUM_ENTITIES - 1)) ? '0 : p + ID_W'(1);
    endfunction

    // Apply one request to the predicted state and build its result
    task automatic run_request(input t_req rq, output t_rsp rs);
        logic [ID_W-1:0] idx;
        idx              = rq.entity_id[ID_W-1:0];
        rs.status        = STS_OK;
        rs.entity_out    = rq.entity_id[ENT_OUT_W-1:0];
        rs.signature_out = '0;
        if (rq.op == OP_CREATE) begin
            if (live_cnt >= CNT_W'(NUM_ENTITIES)) begin
                rs.status     = STS_NO_FREE;
                rs.entity_out = '0;
            end else begin
                rs.entity_out                   = ENT_OUT_W'(free_ring[ring_rd]);
                live_map[free_ring[ring_rd]]    = 1'b1;
                ring_rd                         = ring_adv(ring_rd);
                live_cnt                        = live_cnt + CNT_W'(1);
            end
        end else if (rq.entity_id >= ID_IN_W'(NUM_ENTITIES)) begin
            rs.status = STS_RANGE;
        end else begin
            case (rq.op)
                OP_DESTROY: begin
                    if (!live_map[idx]) begin
                        rs.status = STS_NOT_LIVING;
                    end else begin
                        sig_table[idx]     = '0;
                        live_map[idx]      = 1'b0;
                        free_ring[ring_wr] = idx;
                        ring_wr            = ring_adv(ring_wr);
                        live_cnt           = live_cnt - CNT_W'(1);
                    end
                end
                OP_SET: begin
                    sig_table[idx] = rq.signature_in[SIGNATURE_BITS-1:0];
                end
                default: begin
                    rs.signature_out = SIG_IO_W'(sig_table[idx]);
                end
            endcase
        end
        rs.living_total = TOTAL_W'(live_cnt);
    endtask

    // Compare one result against the oldest expectation
    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (rsp_due.size() == 0) begin
            report($sformatf("result with nothing outstanding: status %0d entity %0d",
                             got.status, got.entity_out));
        end else begin
            want = rsp_due.pop_front();
            if (got.status !== want.status) begin
                report($sformatf("status %0d, want %0d", got.status, want.status));
            end
            if (got.entity_out !== want.entity_out) begin
                report($sformatf("entity_out %0d, want %0d",
                                 got.entity_out, want.entity_out));
            end
            if (got.signature_out !== want.signature_out) begin
                report($sformatf("signature_out %h, want %h",
                                 got.signature_out, want.signature_out));
            end
            if (got.living_total !== want.living_total) begin
                report($sformatf("living_total %0d, want %0d",
                                 got.living_total, want.living_total));
            end
        end
    endtask

    // Track requests and results at every rising edge
    always @(posedge i_clk) begin
        t_rsp rs;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTITIES; i++) begin
                free_ring[i] = ID_W'(i);
                sig_table[i] = '0;
            end
            live_map = '0;
            ring_rd  = '0;
            ring_wr  = '0;
            live_cnt = '0;
            rsp_due.delete();
        end else begin
            if (i_valid === 1'b1) begin
                check_result(i_rsp);
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                run_request(i_req, rs);
                rsp_due = {rsp_due, rs};
            end
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                foreach (rsp_due[k]) begin
                    report($sformatf("result never arrived: entity %0d",
                                     rsp_due[k].entity_out));
                end
            end
        end
        o_pending  <= rsp_due.size();
        o_live_map <= live_map;
        o_errors   <= err_cnt;
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the entity ID allocator: clock, reset, request stimulus and verdict.
module tb;
    import eia_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int HALF       = CLK_PERIOD / 2;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_rsp o_rsp;
    logic chk_end;

    int                      err_total;
    int                      due_cnt;
    logic [NUM_ENTITIES-1:0] live_map;

    always #HALF i_clk = ~i_clk;

    entity_id_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    eia_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (i_req),
        .i_valid    (o_valid),
        .i_rsp      (o_rsp),
        .i_end      (chk_end),
        .o_errors   (err_total),
        .o_pending  (due_cnt),
        .o_live_map (live_map)
    );

    // Hold a request until it is taken, after an optional idle gap
    task automatic send_req(input t_req r, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Drop start and wait until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (due_cnt != 0) @(posedge i_clk);
    endtask

    function automatic t_req mk(input t_op op, input int id, input logic [31:0] sig);
        t_req r;
        r.op           = op;
        r.entity_id    = ID_IN_W'(id);
        r.signature_in = sig;
        return r;
    endfunction

    function automatic int gap_len(input int pct);
        return ($urandom_range(99) < pct) ? $urandom_range(1, 12) : 0;
    endfunction

    function automatic logic [31:0] rand_sig();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    // Pick a living entity from a random starting point, -1 if none
    function automatic int pick_live();
        int base;
        base = $urandom_range(NUM_ENTITIES - 1);
        for (int k = 0; k < NUM_ENTITIES; k++) begin
            if (live_map[ID_W'((base + k) % NUM_ENTITIES)]) begin
                return (base + k) % NUM_ENTITIES;
            end
        end
        return -1;
    endfunction

    // Target mostly living entities, some arbitrary ones and some out of range
    function automatic int pick_target();
        int roll;
        int id;
        roll = $urandom_range(99);
        id   = pick_live();
        if (roll < 70 && id >= 0) begin
            return id;
        end else if (roll < 90) begin
            return $urandom_range(NUM_ENTITIES - 1);
        end
        return $urandom_range(NUM_ENTITIES, 2047);
    endfunction

    function automatic t_req rand_req(input int create_pct, input int destroy_pct);
        int   roll;
        t_req r;
        roll = $urandom_range(99);
        if (roll < create_pct) begin
            r = mk(OP_CREATE, $urandom_range(2047), rand_sig());
        end else if (roll < create_pct + destroy_pct) begin
            r = mk(OP_DESTROY, pick_target(), rand_sig());
        end else if (roll[0]) begin
            r = mk(OP_SET, pick_target(), rand_sig());
        end else begin
            r = mk(OP_GET, pick_target(), rand_sig());
        end
        return r;
    endfunction

    // Stop a hung run
    initial begin
        #(CLK_PERIOD * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int idle_pct;
        start   = 1'b0;
        i_req   = '0;
        chk_end = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: edge ids, every op, range and not-living cases
        send_req(mk(OP_GET, 0, 32'h0), 0);
        send_req(mk(OP_SET, 2047, 32'hFFFF_FFFF), 0);
        send_req(mk(OP_GET, 1024, 32'h0), 0);
        send_req(mk(OP_DESTROY, 1023, 32'h0), 0);
        send_req(mk(OP_DESTROY, 2047, 32'h0), 0);
        send_req(mk(OP_CREATE, 0, 32'h0), 0);
        send_req(mk(OP_CREATE, 0, 32'h0), 2);
        send_req(mk(OP_SET, 0, 32'hFFFF_FFFF), 0);
        send_req(mk(OP_GET, 0, 32'h0), 0);
        send_req(mk(OP_SET, 1, 32'hA5A5_5A5A), 1);
        send_req(mk(OP_SET, 1023, 32'h1234_5678), 0);
        send_req(mk(OP_GET, 1023, 32'h0), 0);
        send_req(mk(OP_DESTROY, 0, 32'h0), 0);
        send_req(mk(OP_DESTROY, 0, 32'h0), 0);
        send_req(mk(OP_GET, 0, 32'h0), 0);
        send_req(mk(OP_CREATE, 2047, 32'hFFFF_FFFF), 0);
        send_req(mk(OP_CREATE, 0, 32'h0), 3);
        send_req(mk(OP_DESTROY, 1, 32'h0), 0);
        send_req(mk(OP_SET, 512, 32'h8000_0001), 0);
        send_req(mk(OP_GET, 512, 32'h0), 0);
        send_req(mk(OP_GET, 1, 32'h0), 0);
        send_req(mk(OP_CREATE, 0, $urandom), 0);
        drain();

        // Random mix, idle density changing every 50 requests
        idle_pct = 0;
        for (int n = 0; n < 330; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 40;
                endcase
            end
            send_req(rand_req(35, 25), gap_len(idle_pct));
        end
        drain();

        // Churn back-to-back with no idle cycles
        for (int n = 0; n < 300; n++) begin
            send_req(rand_req(25, 45), 0);
        end
        drain();

        repeat (8) @(posedge i_clk);
        chk_end <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (err_total == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/eia_pkg.sv
sv/eia_ram.sv
sv/eia_ring.sv
sv/eia_table.sv
sv/entity_id_allocator_unit.sv
verif/eia_checker.sv
verif/tb.sv
